// ----- src/gnft_pkg.sv -----
// Shared constants, codes and beat types for the gradient noise texel block.
`timescale 1ns / 1ps
package gnft_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int MAX_OCTAVES = 16;
	localparam int OCT_W       = $clog2(MAX_OCTAVES);
	localparam int FRAC_BITS   = 28;
	localparam int COORD_W     = 20;
	localparam int DSH_W       = 24;
	localparam int MOD_CELLS   = COORD_W;
	localparam int GRAD_W      = 16;
	localparam int U_W         = FRAC_BITS + 1;
	localparam int V_W         = FRAC_BITS + 2;
	localparam int PROD_W      = GRAD_W + V_W;
	localparam int DOT_W       = 24;
	localparam int TERM_W      = 26;
	localparam int OSUM_W      = 28;
	localparam int ACC_W       = 32;
	localparam int CFG_IDX_W   = 3;

	localparam logic [ACC_W-1:0] OFFSET_Q20 = 32'd985661;
	localparam logic [20:0]      FACTOR_Q20 = 21'd551551;
	localparam logic [20:0]      UNITY_Q20  = 21'd1048576;

	// input item functions
	localparam logic [1:0] FUNC_PERM  = 2'd0;
	localparam logic [1:0] FUNC_GRAD  = 2'd1;
	localparam logic [1:0] FUNC_PIXEL = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TURB    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_XSTEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_YSTEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_XPER    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_YPER    = 3'd6;

	// beat moving along the remainder cell row
	typedef struct packed {
		logic               valid;
		logic               sel;
		logic [COORD_W-1:0] rem;
		logic [DSH_W-1:0]   dsh;
	} mod_beat_t;

	// one lattice corner handed to the corner unit
	typedef struct packed {
		logic                     valid;
		logic                     last;
		logic [U_W-1:0]           ux;
		logic [U_W-1:0]           uy;
		logic signed [V_W-1:0]    vx;
		logic signed [V_W-1:0]    vy;
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
	} corner_beat_t;

	// weighted corner contribution
	typedef struct packed {
		logic                     valid;
		logic                     last;
		logic signed [TERM_W-1:0] term;
	} corner_term_t;

endpackage

// ----- src/gradient_noise_fractal_texel.sv -----
// Top level: fractal 2D gradient noise texel generator with table stores.
// Table-load beats are written to the stores without leaving idle, so another beat can be accepted at once.
// A pixel first sets up the lattice coordinates through the 20-cell remainder
// row, then for each octave (one more than the octave register value) it walks
// four corners through the permutation store, in states RP, RQ, RG and LN per
// corner, and drains the four-stage corner unit.
// Reset clears configuration to defaults and control state; the stores hold
// no reset value and must be loaded before use.
`timescale 1ns / 1ps
module gradient_noise_fractal_texel import gnft_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [1:0]               func,
	input  logic [IDX_W-1:0]         table_index,
	input  logic [IDX_W-1:0]         perm_value,
	input  logic signed [GRAD_W-1:0] grad_x,
	input  logic signed [GRAD_W-1:0] grad_y,
	input  logic [15:0]              pixel_x,
	input  logic [15:0]              pixel_y,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [7:0]               gray_value,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]              cfg_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_FEEDX = 4'd2;
	localparam logic [3:0] ST_FEEDY = 4'd3;
	localparam logic [3:0] ST_WAIT  = 4'd4;
	localparam logic [3:0] ST_RP    = 4'd5;
	localparam logic [3:0] ST_RQ    = 4'd6;
	localparam logic [3:0] ST_RG    = 4'd7;
	localparam logic [3:0] ST_LN    = 4'd8;
	localparam logic [3:0] ST_DR    = 4'd9;
	localparam logic [3:0] ST_OC    = 4'd10;
	localparam logic [3:0] ST_F1    = 4'd11;
	localparam logic [3:0] ST_F2    = 4'd12;

	localparam int POS_W = 48;
	localparam logic [U_W-1:0] ONE_U = U_W'(1) << FRAC_BITS;
	localparam logic signed [V_W-1:0] ONE_V = V_W'(1) << FRAC_BITS;

	// configuration
	logic [OCT_W-1:0] oct_cfg_q;
	logic             turb_q, tile_q;
	logic [31:0]      xstep_q, ystep_q;
	logic [4:0]       xper_q, yper_q;
	logic [4:0]       xpe, ype;

	// control
	logic [3:0]       state_q;
	logic [1:0]       cnt_q;
	logic [OCT_W-1:0] k_q;
	logic             gray_valid_q;
	logic             req_acc, rsp_acc, out_load;

	// payload
	logic [15:0]              pix_x_q, pix_y_q;
	logic [POS_W-1:0]         px_q, py_q;
	logic [COORD_W-1:0]       wx_q, wy_q, perx_q, pery_q;
	logic [FRAC_BITS-1:0]     fracx_q, fracy_q;
	logic [IDX_W-1:0]         ax_q, ay_q;
	logic signed [OSUM_W-1:0] osum_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [54:0]       prod_q;
	logic [7:0]               gray_q;

	// stores
	logic                     perm_we, grad_we;
	logic [IDX_W-1:0]         perm_raddr;
	logic [IDX_W-1:0]         perm_rdata;
	logic [2*GRAD_W-1:0]      grad_rdata;

	mod_beat_t    chain [MOD_CELLS+1];
	corner_beat_t cbeat;
	corner_term_t cterm;

	logic                     ci, cj;
	logic [COORD_W-1:0]       wx_inc, wy_inc, wxc, wyc;
	logic [IDX_W-1:0]         cx_idx, cy_idx;
	logic signed [OSUM_W-1:0] oct_val, oct_abs;
	logic signed [32:0]       sumoff;
	logic [20:0]              fac;
	logic signed [63:0]       scaled;
	logic signed [23:0]       vtop;
	logic [7:0]               gray_sat;

	assign xpe = (xper_q == 5'd0) ? 5'd1 : xper_q;
	assign ype = (yper_q == 5'd0) ? 5'd1 : yper_q;

	assign req_stall = state_q != ST_IDLE;
	assign req_acc   = req_valid && !req_stall;
	assign rsp_acc   = gray_valid_q && !rsp_stall;
	assign out_load  = (state_q == ST_F2) && (!gray_valid_q || !rsp_stall);
	assign cfg_ready = 1'b1;
	assign rsp_valid  = gray_valid_q;
	assign gray_value = gray_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cfg_q <= OCT_W'(1);
			turb_q    <= 1'b0;
			tile_q    <= 1'b0;
			xstep_q   <= 32'h1000_0000;
			ystep_q   <= 32'h1000_0000;
			xper_q    <= 5'd4;
			yper_q    <= 5'd4;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OCTAVES: oct_cfg_q <= cfg_data[OCT_W-1:0];
				CFG_TURB:    turb_q    <= cfg_data[0];
				CFG_TILE:    tile_q    <= cfg_data[0];
				CFG_XSTEP:   xstep_q   <= cfg_data;
				CFG_YSTEP:   ystep_q   <= cfg_data;
				CFG_XPER:    xper_q    <= cfg_data[4:0];
				CFG_YPER:    yper_q    <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// table stores
	assign perm_we = req_acc && (func == FUNC_PERM);
	assign grad_we = req_acc && (func == FUNC_GRAD);

	gnft_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_DEPTH)) u_perm_ram (
		.clk   (clk),
		.we    (perm_we),
		.waddr (table_index),
		.wdata (perm_value),
		.raddr (perm_raddr),
		.rdata (perm_rdata)
	);

	gnft_ram #(.WIDTH(2*GRAD_W), .DEPTH(TABLE_DEPTH)) u_grad_ram (
		.clk   (clk),
		.we    (grad_we),
		.waddr (table_index),
		.wdata ({grad_y, grad_x}),
		.raddr (perm_rdata),
		.rdata (grad_rdata)
	);

	// remainder cell row: base lattice coordinate modulo tile period
	assign chain[0].valid = (state_q == ST_FEEDX) || (state_q == ST_FEEDY);
	assign chain[0].sel   = state_q == ST_FEEDY;
	assign chain[0].rem   = (state_q == ST_FEEDY) ? py_q[POS_W-1:FRAC_BITS]
		: px_q[POS_W-1:FRAC_BITS];
	assign chain[0].dsh   = DSH_W'((state_q == ST_FEEDY) ? ype : xpe) << (COORD_W - 1);

	for (genvar c = 0; c < MOD_CELLS; c++) begin : g_cell
		gnft_mod_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[c]),
			.dout   (chain[c+1])
		);
	end

	// corner coordinates
	assign ci     = cnt_q[1];
	assign cj     = cnt_q[0];
	assign wx_inc = wx_q + COORD_W'(1);
	assign wy_inc = wy_q + COORD_W'(1);
	assign wxc    = ci ? ((wx_inc == perx_q) ? '0 : wx_inc) : wx_q;
	assign wyc    = cj ? ((wy_inc == pery_q) ? '0 : wy_inc) : wy_q;
	assign cx_idx = tile_q ? wxc[IDX_W-1:0] : ax_q + IDX_W'(ci);
	assign cy_idx = tile_q ? wyc[IDX_W-1:0] : ay_q + IDX_W'(cj);

	assign perm_raddr = (state_q == ST_RP) ? cy_idx : cx_idx + perm_rdata;

	// corner launch
	always_comb begin
		cbeat.valid = state_q == ST_LN;
		cbeat.last  = cnt_q == 2'd3;
		cbeat.ux    = ci ? ONE_U - U_W'(fracx_q) : U_W'(fracx_q);
		cbeat.uy    = cj ? ONE_U - U_W'(fracy_q) : U_W'(fracy_q);
		cbeat.vx    = $signed(V_W'(fracx_q)) - (ci ? ONE_V : '0);
		cbeat.vy    = $signed(V_W'(fracy_q)) - (cj ? ONE_V : '0);
		cbeat.gx    = $signed(grad_rdata[GRAD_W-1:0]);
		cbeat.gy    = $signed(grad_rdata[2*GRAD_W-1:GRAD_W]);
	end

	gnft_corner u_corner (
		.clk    (clk),
		.arst_n (arst_n),
		.cin    (cbeat),
		.cout   (cterm)
	);

	// octave value and final scaling
	assign oct_val = osum_q >>> k_q;
	assign oct_abs = (turb_q && oct_val < 0) ? -oct_val : oct_val;
	assign sumoff  = 33'(acc_q) + (turb_q ? 33'sd0 : $signed({1'b0, OFFSET_Q20}));
	assign fac     = turb_q ? UNITY_Q20 : FACTOR_Q20;
	assign scaled  = (64'(prod_q) <<< 8) - 64'(prod_q);
	assign vtop    = scaled[63:40];
	assign gray_sat = (vtop < 0) ? 8'd0 : ((vtop > 24'sd255) ? 8'd255 : vtop[7:0]);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			k_q          <= '0;
			gray_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				gray_valid_q <= 1'b1;
			end else if (rsp_acc) begin
				gray_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && func == FUNC_PIXEL) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_FEEDX;
				ST_FEEDX: state_q <= ST_FEEDY;
				ST_FEEDY: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (chain[MOD_CELLS].valid && chain[MOD_CELLS].sel) begin
						k_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_RP;
					end
				end
				ST_RP: state_q <= ST_RQ;
				ST_RQ: state_q <= ST_RG;
				ST_RG: state_q <= ST_LN;
				ST_LN: begin
					if (cnt_q == 2'd3) begin
						state_q <= ST_DR;
					end else begin
						cnt_q   <= cnt_q + 2'd1;
						state_q <= ST_RP;
					end
				end
				ST_DR: begin
					if (cterm.valid && cterm.last) begin
						state_q <= ST_OC;
					end
				end
				ST_OC: begin
					if (k_q == oct_cfg_q) begin
						state_q <= ST_F1;
					end else begin
						k_q     <= k_q + OCT_W'(1);
						cnt_q   <= '0;
						state_q <= ST_RP;
					end
				end
				ST_F1: state_q <= ST_F2;
				ST_F2: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req_acc) begin
			pix_x_q <= pixel_x;
			pix_y_q <= pixel_y;
		end
		if (state_q == ST_MUL) begin
			px_q <= POS_W'(pix_x_q) * POS_W'(xstep_q);
			py_q <= POS_W'(pix_y_q) * POS_W'(ystep_q);
		end
		// capture wrapped base coordinates, load octave position
		if (state_q == ST_WAIT && chain[MOD_CELLS].valid) begin
			if (chain[MOD_CELLS].sel) begin
				wy_q    <= chain[MOD_CELLS].rem;
				perx_q  <= COORD_W'(xpe);
				pery_q  <= COORD_W'(ype);
				fracx_q <= px_q[FRAC_BITS-1:0];
				fracy_q <= py_q[FRAC_BITS-1:0];
				ax_q    <= px_q[FRAC_BITS+IDX_W-1:FRAC_BITS];
				ay_q    <= py_q[FRAC_BITS+IDX_W-1:FRAC_BITS];
				acc_q   <= '0;
				osum_q  <= '0;
			end else begin
				wx_q <= chain[MOD_CELLS].rem;
			end
		end
		// gather corner terms, close the octave and double the scale
		if (state_q == ST_OC) begin
			osum_q  <= '0;
			acc_q   <= acc_q + ACC_W'(oct_abs);
			fracx_q <= fracx_q << 1;
			fracy_q <= fracy_q << 1;
			ax_q    <= {ax_q[IDX_W-2:0], fracx_q[FRAC_BITS-1]};
			ay_q    <= {ay_q[IDX_W-2:0], fracy_q[FRAC_BITS-1]};
			wx_q    <= {wx_q[COORD_W-2:0], fracx_q[FRAC_BITS-1]};
			wy_q    <= {wy_q[COORD_W-2:0], fracy_q[FRAC_BITS-1]};
			perx_q  <= perx_q << 1;
			pery_q  <= pery_q << 1;
		end else if (cterm.valid) begin
			osum_q <= osum_q + OSUM_W'(cterm.term);
		end
		if (state_q == ST_F1) begin
			prod_q <= 55'(sumoff) * 55'($signed({1'b0, fac}));
		end
		if (out_load) begin
			gray_q <= gray_sat;
		end
	end

`ifndef SYNTH
	a_chain_out_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		chain[MOD_CELLS].valid |-> state_q == ST_WAIT)
		else $error("remainder row beat outside coordinate wait");

	a_term_in_octave: assert property (@(posedge clk) disable iff (!arst_n)
		cterm.valid |-> (state_q == ST_RP || state_q == ST_RQ || state_q == ST_RG
			|| state_q == ST_LN || state_q == ST_DR))
		else $error("corner term outside octave walk");

	a_hold_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F2 && gray_valid_q && rsp_stall) |=> state_q == ST_F2)
		else $error("result overwritten while output stalled");
`endif

endmodule

// ----- src/gnft_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module gnft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/gnft_mod_cell.sv -----
// One restoring remainder cell: conditional subtract, divisor moves down a bit.
`timescale 1ns / 1ps
module gnft_mod_cell import gnft_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mod_beat_t din,
	output mod_beat_t dout
);

	logic             fits;
	logic [DSH_W-1:0] rem_wide;
	mod_beat_t        beat_q;

	assign rem_wide = DSH_W'(din.rem);
	assign fits     = rem_wide >= din.dsh;

	// subtract when the shifted divisor fits, hand on to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else begin
			beat_q.valid <= din.valid;
			beat_q.sel   <= din.sel;
			beat_q.rem   <= fits ? COORD_W'(rem_wide - din.dsh) : din.rem;
			beat_q.dsh   <= din.dsh >> 1;
		end
	end

	assign dout = beat_q;

endmodule

// ----- src/gnft_corner.sv -----
// Corner unit: cubic weights, gradient dot product and weighted term, four stages.
`timescale 1ns / 1ps
module gnft_corner import gnft_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  corner_beat_t cin,
	output corner_term_t cout
);

	localparam logic [U_W-1:0]   ONE_U   = U_W'(1) << FRAC_BITS;
	localparam logic [U_W:0]     THREE_U = (U_W+1)'(3) << FRAC_BITS;

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic                      last_s1, last_s2, last_s3, last_s4;
	logic [U_W-1:0]            ux_s1, uy_s1, u2x_s1, u2y_s1;
	logic signed [PROD_W-1:0]  p1_s1, p2_s1;
	logic [U_W-1:0]            cx_s2, cy_s2;
	logic signed [DOT_W-1:0]   dot_s2, dot_s3;
	logic [U_W-1:0]            wt_s3;
	logic signed [TERM_W-1:0]  term_s4;

	logic [2*U_W-1:0]          sqx, sqy;
	logic signed [PROD_W-1:0]  p1, p2;
	logic [U_W:0]              kx, ky;
	logic [2*U_W:0]            ckx, cky;
	logic signed [PROD_W:0]    dsum;
	logic [U_W-1:0]            wx, wy;
	logic [2*U_W-1:0]          wprod;
	logic signed [DOT_W+U_W:0] tprod;

	// stage 1: squares of weight arguments, gradient products
	assign sqx = (2*U_W)'(cin.ux) * (2*U_W)'(cin.ux);
	assign sqy = (2*U_W)'(cin.uy) * (2*U_W)'(cin.uy);
	assign p1  = PROD_W'(cin.gx) * PROD_W'(cin.vx);
	assign p2  = PROD_W'(cin.gy) * PROD_W'(cin.vy);

	// stage 2: cubic term, floored dot product
	assign kx   = THREE_U - {ux_s1, 1'b0};
	assign ky   = THREE_U - {uy_s1, 1'b0};
	assign ckx  = (2*U_W+1)'(kx) * (2*U_W+1)'(u2x_s1);
	assign cky  = (2*U_W+1)'(ky) * (2*U_W+1)'(u2y_s1);
	assign dsum = (PROD_W+1)'(p1_s1) + (PROD_W+1)'(p2_s1);

	// stage 3: corner weight from both axis weights
	assign wx    = ONE_U - cx_s2;
	assign wy    = ONE_U - cy_s2;
	assign wprod = (2*U_W)'(wx) * (2*U_W)'(wy);

	// stage 4: weighted term
	assign tprod = (DOT_W+U_W+1)'(dot_s3) * (DOT_W+U_W+1)'($signed({1'b0, wt_s3}));

	// advance valid and last flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cin.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		last_s1 <= cin.last;
		ux_s1   <= cin.ux;
		uy_s1   <= cin.uy;
		u2x_s1  <= sqx[FRAC_BITS+U_W-1:FRAC_BITS];
		u2y_s1  <= sqy[FRAC_BITS+U_W-1:FRAC_BITS];
		p1_s1   <= p1;
		p2_s1   <= p2;

		last_s2 <= last_s1;
		cx_s2   <= ckx[FRAC_BITS+U_W-1:FRAC_BITS];
		cy_s2   <= cky[FRAC_BITS+U_W-1:FRAC_BITS];
		dot_s2  <= dsum[23+DOT_W-1:23];

		last_s3 <= last_s2;
		wt_s3   <= wprod[FRAC_BITS+U_W-1:FRAC_BITS];
		dot_s3  <= dot_s2;

		last_s4 <= last_s3;
		term_s4 <= tprod[FRAC_BITS+TERM_W-1:FRAC_BITS];
	end

	assign cout.valid = v_s4;
	assign cout.last  = last_s4;
	assign cout.term  = term_s4;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the gradient noise texel generator.
`timescale 1ns / 1ps
module tb_top;
	import gnft_pkg::*;

	localparam logic [1:0]           FUNC_IGNORED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 3'd7;
	localparam longint               ONE_Q28      = 64'sd1 << FRAC_BITS;
	localparam int                   DRAIN_CYCLES = 400;
	localparam int                   STALL_LIMIT  = 20000;

	typedef struct {
		logic [1:0]         fn;
		logic [IDX_W-1:0]   idx;
		logic [IDX_W-1:0]   pv;
		logic [GRAD_W-1:0]  gx;
		logic [GRAD_W-1:0]  gy;
		logic [15:0]        px;
		logic [15:0]        py;
	} texel_req_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [1:0]               func = '0;
	logic [IDX_W-1:0]         table_index = '0;
	logic [IDX_W-1:0]         perm_value = '0;
	logic signed [GRAD_W-1:0] grad_x = '0;
	logic signed [GRAD_W-1:0] grad_y = '0;
	logic [15:0]              pixel_x = '0;
	logic [15:0]              pixel_y = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic [7:0]               gray_value;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [31:0]              cfg_data = '0;

	// predictor state
	logic [IDX_W-1:0]  perm_mem [TABLE_DEPTH];
	logic [31:0]       grad_mem [TABLE_DEPTH];
	logic [3:0]        octaves_m1 = 4'd1;
	logic              turb_on = 1'b0;
	logic              tile_on = 1'b0;
	logic [31:0]       step_x = 32'h1000_0000;
	logic [31:0]       step_y = 32'h1000_0000;
	logic [4:0]        period_x = 5'd4;
	logic [4:0]        period_y = 5'd4;

	texel_req_t  pending_reqs [$];
	logic [7:0]  gray_expected [$];
	int          fail_count = 0;
	bit          no_gaps = 1'b0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;

	gradient_noise_fractal_texel u_top (.*);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int draw_wait();
		return no_gaps ? 0 : $urandom_range(0, 10);
	endfunction

	// cubic corner weight in Q.28
	function automatic longint corner_weight(longint t);
		longint u, u2, c;
		u = (t < 0) ? -t : t;
		u2 = (u * u) >>> FRAC_BITS;
		c = ((3 * ONE_Q28 - 2 * u) * u2) >>> FRAC_BITS;
		return ONE_Q28 - c;
	endfunction

	// one octave of gradient noise, already divided by its scale
	function automatic longint octave_value(logic [63:0] px, logic [63:0] py, int k);
		logic [63:0]        sx, sy, ax, ay, cx, cy, wrap_x, wrap_y;
		logic [IDX_W-1:0]   n;
		logic signed [15:0] gxs, gys;
		longint             fx, fy, vx, vy, dot, w, sum;
		sx = px << k;
		sy = py << k;
		ax = sx >> FRAC_BITS;
		ay = sy >> FRAC_BITS;
		fx = longint'(sx[FRAC_BITS-1:0]);
		fy = longint'(sy[FRAC_BITS-1:0]);
		wrap_x = 64'((period_x == 0) ? 5'd1 : period_x) << k;
		wrap_y = 64'((period_y == 0) ? 5'd1 : period_y) << k;
		sum = 0;
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				cx = ax + i;
				cy = ay + j;
				if (tile_on) begin
					cx = cx % wrap_x;
					cy = cy % wrap_y;
				end
				n = perm_mem[cy[IDX_W-1:0]];
				n = perm_mem[IDX_W'(cx + n)];
				gxs = grad_mem[n][15:0];
				gys = grad_mem[n][31:16];
				vx = fx - i * ONE_Q28;
				vy = fy - j * ONE_Q28;
				dot = (longint'(gxs) * vx + longint'(gys) * vy) >>> 23;
				w = (corner_weight(vx) * corner_weight(vy)) >>> FRAC_BITS;
				sum += (dot * w) >>> FRAC_BITS;
			end
		end
		return sum >>> k;
	endfunction

	// apply one accepted beat to the stores, or predict its gray byte
	function automatic void predict_texel(texel_req_t r);
		logic [63:0] px, py;
		longint      acc, o, off, fac, v;
		case (r.fn)
			FUNC_PERM: perm_mem[r.idx] = r.pv;
			FUNC_GRAD: grad_mem[r.idx] = {r.gy, r.gx};
			FUNC_PIXEL: begin
				px = 64'(r.px) * 64'(step_x);
				py = 64'(r.py) * 64'(step_y);
				acc = 0;
				for (int k = 0; k <= octaves_m1; k++) begin
					o = octave_value(px, py, k);
					if (turb_on && o < 0)
						o = -o;
					acc += o;
				end
				off = turb_on ? 0 : longint'(OFFSET_Q20);
				fac = turb_on ? longint'(UNITY_Q20) : longint'(FACTOR_Q20);
				v = ((acc + off) * fac * 255) >>> 40;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				gray_expected.push_back(8'(v));
			end
			default: ;
		endcase
	endfunction

	// request driver: predict on each accepted beat, then load the next one
	always @(posedge clk or negedge arst_n) begin
		texel_req_t r;
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (req_valid && !req_stall) begin
				r.fn = func; r.idx = table_index; r.pv = perm_value;
				r.gx = grad_x; r.gy = grad_y; r.px = pixel_x; r.py = pixel_y;
				predict_texel(r);
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					r = pending_reqs.pop_front();
					func <= r.fn; table_index <= r.idx; perm_value <= r.pv;
					grad_x <= r.gx; grad_y <= r.gy; pixel_x <= r.px; pixel_y <= r.py;
					req_valid <= 1'b1;
					gap_left = draw_wait();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor: check each accepted beat and draw the next stall
	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (gray_expected.size() == 0) begin
					$error("gray_value unexpected beat, actual %0d", gray_value);
					fail_count++;
				end else begin
					want = gray_expected.pop_front();
					if (gray_value !== want) begin
						$error("gray_value expected %0d actual %0d", want, gray_value);
						fail_count++;
					end
				end
				stall_left = draw_wait();
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp_stall <= (stall_left > 0);
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** gradient_noise_fractal_texel: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_OCTAVES: octaves_m1 = data[3:0];
			CFG_TURB:    turb_on = data[0];
			CFG_TILE:    tile_on = data[0];
			CFG_XSTEP:   step_x = data;
			CFG_YSTEP:   step_y = data;
			CFG_XPER:    period_x = data[4:0];
			CFG_YPER:    period_y = data[4:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [3:0] oc, logic tu, logic ti, logic [31:0] xs,
			logic [31:0] ys, logic [4:0] xp, logic [4:0] yp);
		write_reg(CFG_OCTAVES, 32'(oc));
		write_reg(CFG_TURB, 32'(tu));
		write_reg(CFG_TILE, 32'(ti));
		write_reg(CFG_XSTEP, xs);
		write_reg(CFG_YSTEP, ys);
		write_reg(CFG_XPER, 32'(xp));
		write_reg(CFG_YPER, 32'(yp));
	endtask

	// wait for every expected byte, then let a silent beat finish
	task automatic drain();
		while (pending_reqs.size() > 0 || req_valid || gray_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void push_req(logic [1:0] fn, logic [IDX_W-1:0] idx,
			logic [IDX_W-1:0] pv, logic [15:0] gx, logic [15:0] gy,
			logic [15:0] px, logic [15:0] py);
		texel_req_t r;
		r.fn = fn; r.idx = idx; r.pv = pv; r.gx = gx; r.gy = gy; r.px = px; r.py = py;
		pending_reqs.push_back(r);
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'h1000_0000;
			2: return $urandom_range(0, 32'h0FFF_FFFF);
			default: return $urandom_range(0, 32'h0010_0000);
		endcase
	endfunction

	function automatic logic [15:0] pick_coord();
		return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 255)) : 16'($urandom());
	endfunction

	// random mix: mostly pixels, with table rewrites and ignored beats
	function automatic void push_random();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			push_req(FUNC_PERM, 6'($urandom()), 6'($urandom()), '0, '0, '0, '0);
		else if (sel < 16)
			push_req(FUNC_GRAD, 6'($urandom()), '0, 16'($urandom()), 16'($urandom()),
				'0, '0);
		else if (sel < 19)
			push_req(FUNC_IGNORED, 6'($urandom()), 6'($urandom()), 16'($urandom()),
				16'($urandom()), 16'($urandom()), 16'($urandom()));
		else
			push_req(FUNC_PIXEL, '0, '0, '0, '0, pick_coord(), pick_coord());
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both stores before any pixel reads them, extremes included
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			push_req(FUNC_PERM, IDX_W'(i), (i == 0) ? 6'd63 : (i == 1) ? 6'd0 : 6'($urandom()),
				'0, '0, '0, '0);
			push_req(FUNC_GRAD, IDX_W'(i), '0,
				(i == 0) ? 16'h8000 : (i == 1) ? 16'h7FFF : 16'($urandom()),
				(i == 0) ? 16'h7FFF : (i == 1) ? 16'h8000 : 16'($urandom()), '0, '0);
		end
		// directed pixels at reset settings
		push_req(FUNC_PIXEL, '0, '0, '0, '0, 16'h0000, 16'h0000);
		push_req(FUNC_PIXEL, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF);
		push_req(FUNC_PIXEL, '0, '0, '0, '0, 16'h0000, 16'hFFFF);
		push_req(FUNC_PIXEL, '0, '0, '0, '0, 16'h0003, 16'h0007);
		push_req(FUNC_IGNORED, 6'h3F, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_req(FUNC_PIXEL, '0, '0, '0, '0, 16'h0001, 16'h0002);
		drain();

		// extremes: all octaves, turbulence, tiling with periods zero and 16
		write_all(4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 5'd16);
		write_reg(CFG_SPARE, 32'hFFFF_FFFF);
		push_req(FUNC_PIXEL, '0, '0, '0, '0, 16'hFFFF, 16'hFFFF);
		push_req(FUNC_PIXEL, '0, '0, '0, '0, 16'h0000, 16'h0000);
		push_req(FUNC_PIXEL, '0, '0, '0, '0, 16'h1234, 16'hABCD);
		drain();
		write_all(4'd0, 1'b0, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 5'd31, 5'd1);
		push_req(FUNC_PIXEL, '0, '0, '0, '0, 16'hFFFF, 16'h0001);
		push_req(FUNC_PIXEL, '0, '0, '0, '0, 16'h8000, 16'hFFFF);
		drain();

		// random phases with fresh settings each time
		for (int p = 0; p < 10; p++) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			write_all(($urandom_range(0, 4) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 3)),
				1'($urandom()), 1'($urandom()), pick_step(), pick_step(),
				5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
			for (int n = 0; n < 150; n++)
				push_random();
			drain();
		end

		if (fail_count == 0)
			$display("** gradient_noise_fractal_texel: PASSED **");
		else
			$display("** gradient_noise_fractal_texel: FAILED **");
		$finish;
	end

endmodule

// ----- gradient_noise_fractal_texel.f -----
src/gnft_pkg.sv
src/gnft_ram.sv
src/gnft_mod_cell.sv
src/gnft_corner.sv
src/gradient_noise_fractal_texel.sv
tb/sv/tb_top.sv
